[rtl/core/pmt_pkg.sv]
// Shared types and constants for the pair match min/max table.
// No dependencies; used by pmt_index, pmt_update and the top level.
package pmt_pkg;

  localparam int READ_ID_W = 7;
  localparam int CFG_W     = 7;
  localparam int SCORE_W   = 64;
  localparam int FREQ_W    = 32;
  localparam int COUNT_W   = 16;

  // triangular index arithmetic: (2n - a) is one bit wider than an id
  localparam int PROD_W = 2 * READ_ID_W + 1;
  localparam int IDX_W  = 2 * READ_ID_W;

  localparam int MAX_READS_DEF = 64;
  localparam int ID_MAX        = (1 << READ_ID_W) - 1;

  localparam logic [CFG_W-1:0]   NUM_READS_RST = CFG_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } pmt_op_t;

  typedef enum logic {
    STAT_OK  = 1'b0,
    STAT_BAD = 1'b1
  } pmt_status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [SCORE_W-1:0] lo_score;
    logic [FREQ_W-1:0]         lo_freq;
    logic signed [SCORE_W-1:0] hi_score;
    logic [FREQ_W-1:0]         hi_freq;
  } pmt_entry_t;

  // pair check result: in-range flag and flat table index
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } pmt_loc_t;

endpackage

[rtl/core/pair_match_min_max_table.sv]
// Pair match min/max table: top level with RAM, modify stage and output register.
// Depends on pmt_pkg, pmt_ram, pmt_index, pmt_update.
//
// Usage:
//  - Input channel (in_*): one word per operation. Update (in_operation = 0)
//    folds a shared seed's score/frequency into the entry of pair (a,b);
//    read (in_operation = 1) returns the entry untouched.
//  - Output channel (out_*): exactly one word per input word, in order.
//    An out-of-range pair gives out_status = 1, zero fields, no table change.
//  - cfg_we / cfg_num_reads sets n for the index; write only while idle.
//  - A taken word passes stage 1 (RAM read, modify), then the output register.
//  - Throughput: one word per cycle while out_stall allows. The table RAM is
//    read when a word is taken and written back as it leaves stage 1; a
//    back-to-back hit on the same entry is served from the write-back register.
//  - Reset: the table is swept to zero, one entry per cycle, over all
//    MAX_READS*(MAX_READS-1)/2 entries (2016 at the default); in_stall is
//    high for the whole sweep. num_reads returns to 64.
//  - out_stall holds the output register; the modify stage then stalls,
//    and in_stall rises only when that stage is also full.
module pair_match_min_max_table
  import pmt_pkg::*;
#(
  parameter int MAX_READS = MAX_READS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_num_reads,
  // input words
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [READ_ID_W-1:0]      in_read_a,
  input  logic [READ_ID_W-1:0]      in_read_b,
  input  logic signed [SCORE_W-1:0] in_seed_score,
  input  logic [FREQ_W-1:0]         in_seed_freq,
  // result words
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_status,
  output logic [COUNT_W-1:0]        out_match_count,
  output logic signed [SCORE_W-1:0] out_lowest_score,
  output logic [FREQ_W-1:0]         out_lowest_freq,
  output logic signed [SCORE_W-1:0] out_highest_score,
  output logic [FREQ_W-1:0]         out_highest_freq
);

  localparam int DEPTH   = (MAX_READS * (MAX_READS - 1)) / 2;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = $bits(pmt_entry_t);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // ---------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] num_reads_r;

  // ---------------------------------------------------------------
  // Control / pipeline state
  // ---------------------------------------------------------------
  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic              wb_vld_r, wb_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // stage 1 payload (read data arrives from RAM in this stage)
  pmt_op_t                   s1_op_r;
  logic                      s1_ok_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  logic signed [SCORE_W-1:0] s1_score_r;
  logic [FREQ_W-1:0]         s1_freq_r;

  // write-back copy for same-entry forwarding
  logic [ADDR_W-1:0] wb_addr_r;
  pmt_entry_t        wb_entry_r;

  // output register
  pmt_status_t out_status_r;
  pmt_entry_t  out_entry_r;

  pmt_loc_t          loc;
  logic              in_acc;
  logic              s1_adv;
  logic              item_we;
  logic              upd_we;
  logic              fwd_hit;
  pmt_entry_t        cur_entry;
  pmt_entry_t        nxt_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  // ---------------------------------------------------------------
  // Index and range check straight off the input ports
  // ---------------------------------------------------------------
  pmt_index #(
    .MAX_READS (MAX_READS)
  ) u_index (
    .num_reads (num_reads_r),
    .read_a    (in_read_a),
    .read_b    (in_read_b),
    .loc       (loc)
  );

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  assign s1_adv   = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_vld_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // Table RAM: read on accept, write back from stage 1 or sweep
  // ---------------------------------------------------------------
  assign item_we   = s1_adv && s1_ok_r && upd_we;
  assign ram_we    = clearing_r || item_we;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clearing_r ? '0 : nxt_entry;

  pmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (ADDR_W'(loc.idx)),
    .rdata (ram_rdata)
  );

  // RAM is read-first: the word written the cycle this item read is stale
  assign fwd_hit   = wb_vld_r && (wb_addr_r == s1_addr_r);
  assign cur_entry = fwd_hit ? wb_entry_r : pmt_entry_t'(ram_rdata);

  pmt_update u_update (
    .op         (s1_op_r),
    .seed_score (s1_score_r),
    .seed_freq  (s1_freq_r),
    .cur        (cur_entry),
    .nxt        (nxt_entry),
    .we         (upd_we)
  );

  // ---------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end
    end

    priority if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end

    wb_vld_nxt = s1_adv ? item_we : wb_vld_r;

    priority if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_reads_r <= NUM_READS_RST;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_vld_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_reads_r <= cfg_num_reads;
      end
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_vld_r    <= s1_vld_nxt;
      wb_vld_r    <= wb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= pmt_op_t'(in_operation);
      s1_ok_r    <= loc.ok;
      s1_addr_r  <= ADDR_W'(loc.idx);
      s1_score_r <= in_seed_score;
      s1_freq_r  <= in_seed_freq;
    end
    if (item_we) begin
      wb_addr_r  <= s1_addr_r;
      wb_entry_r <= nxt_entry;
    end
    if (s1_adv) begin
      if (s1_ok_r) begin
        out_status_r <= STAT_OK;
        out_entry_r  <= nxt_entry;
      end else begin
        out_status_r <= STAT_BAD;
        out_entry_r  <= '0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_count   = out_entry_r.count;
  assign out_lowest_score  = out_entry_r.lo_score;
  assign out_lowest_freq   = out_entry_r.lo_freq;
  assign out_highest_score = out_entry_r.hi_score;
  assign out_highest_freq  = out_entry_r.hi_freq;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // no word may enter while the table sweep is running
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall)
    else $error("input taken during table sweep");

  // an item write-back always lands inside the table
  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_we |-> (s1_addr_r <= LAST_ADDR))
    else $error("write-back beyond table depth");

  // a stalled stage-1 item keeps its address so forwarding stays valid
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_addr_r)))
    else $error("stage 1 item lost while stalled");

  // an update to a valid pair always leaves a nonzero count
  a_update_count: assert property (@(posedge clk) disable iff (!rst_n)
    item_we |-> (nxt_entry.count != '0))
    else $error("update left zero match count");

endmodule

[rtl/core/pmt_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first when both ports hit the same address. No dependencies.
module pmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pmt_index.sv]
// Pair range check and triangular index: ((2n-a)(a-1))/2 + b-a-1.
// Depends on pmt_pkg.
module pmt_index
  import pmt_pkg::*;
#(
  parameter int MAX_READS = MAX_READS_DEF
) (
  input  logic [CFG_W-1:0]     num_reads,
  input  logic [READ_ID_W-1:0] read_a,
  input  logic [READ_ID_W-1:0] read_b,
  output pmt_loc_t             loc
);

  // n is capped by the table size and can never exceed the id range
  localparam int NCAP = (MAX_READS > ID_MAX) ? ID_MAX : MAX_READS;
  localparam logic [CFG_W-1:0] N_CAP = CFG_W'(NCAP);

  logic [CFG_W-1:0]     n_eff;
  logic [READ_ID_W:0]   two_n_m_a;
  logic [READ_ID_W-1:0] a_m1;
  logic [READ_ID_W-1:0] offs;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    n_eff     = (num_reads > N_CAP) ? N_CAP : num_reads;
    two_n_m_a = {n_eff, 1'b0} - {1'b0, read_a};
    a_m1      = read_a - READ_ID_W'(1);
    offs      = read_b - read_a - READ_ID_W'(1);
    prod      = PROD_W'(two_n_m_a) * PROD_W'(a_m1);
    loc.ok    = (read_a != '0) && (read_a < read_b) &&
                (CFG_W'(read_b) <= n_eff);
    loc.idx   = prod[PROD_W-1:1] + IDX_W'(offs);
  end

endmodule

[rtl/core/pmt_update.sv]
// Entry modify step: count bump with saturation and min/max replacement.
// Depends on pmt_pkg.
module pmt_update
  import pmt_pkg::*;
(
  input  pmt_op_t                   op,
  input  logic signed [SCORE_W-1:0] seed_score,
  input  logic [FREQ_W-1:0]         seed_freq,
  input  pmt_entry_t                cur,
  output pmt_entry_t                nxt,
  output logic                      we
);

  always_comb begin
    nxt = cur;
    we  = 1'b0;
    unique case (op)
      OP_UPDATE: begin
        we = 1'b1;
        if (cur.count == '0) begin
          nxt.count    = COUNT_W'(1);
          nxt.lo_score = seed_score;
          nxt.lo_freq  = seed_freq;
          nxt.hi_score = seed_score;
          nxt.hi_freq  = seed_freq;
        end else begin
          if (cur.count != COUNT_MAX) begin
            nxt.count = cur.count + COUNT_W'(1);
          end
          // min has priority; a new max only when not a new min
          if (seed_score < cur.lo_score) begin
            nxt.lo_score = seed_score;
            nxt.lo_freq  = seed_freq;
          end else if (cur.hi_score < seed_score) begin
            nxt.hi_score = seed_score;
            nxt.hi_freq  = seed_freq;
          end
        end
      end
      OP_READ: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

endmodule

[tb/sv/tb_pair_match_min_max_table.sv]
// Self-checking testbench for pair_match_min_max_table: directed table, random words,
// a back-pressure stretch and a full-rate tail, checked against the model or by hand.
// Depends on pmt_pkg and the pair_match_min_max_table RTL.
module tb_pair_match_min_max_table;
  import pmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_READS = MAX_READS_DEF;
  localparam int TABLE_DEPTH  = (TB_MAX_READS * (TB_MAX_READS - 1)) / 2;
  localparam int REPORT_LIMIT = 10;
  localparam int TAIL_UPDATES = 64;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

  // one result word as seen on the out_* ports
  typedef struct packed {
    pmt_status_t               status;
    logic [COUNT_W-1:0]        count;
    logic signed [SCORE_W-1:0] lo_score;
    logic [FREQ_W-1:0]         lo_freq;
    logic signed [SCORE_W-1:0] hi_score;
    logic [FREQ_W-1:0]         hi_freq;
  } pair_result_t;

  // one row of the directed table; fixed_res is used only when has_fixed is set
  typedef struct {
    pmt_op_t                   op;
    logic [READ_ID_W-1:0]      a;
    logic [READ_ID_W-1:0]      b;
    logic signed [SCORE_W-1:0] score;
    logic [FREQ_W-1:0]         freq;
    bit                        has_fixed;
    pair_result_t              fixed_res;
  } pair_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_W-1:0]          cfg_num_reads;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_operation;
  logic [READ_ID_W-1:0]      in_read_a;
  logic [READ_ID_W-1:0]      in_read_b;
  logic signed [SCORE_W-1:0] in_seed_score;
  logic [FREQ_W-1:0]         in_seed_freq;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_status;
  logic [COUNT_W-1:0]        out_match_count;
  logic signed [SCORE_W-1:0] out_lowest_score;
  logic [FREQ_W-1:0]         out_lowest_freq;
  logic signed [SCORE_W-1:0] out_highest_score;
  logic [FREQ_W-1:0]         out_highest_freq;

  // model state: our own copy of the pair table and of num_reads
  pmt_entry_t   pair_entries [TABLE_DEPTH];
  logic [CFG_W-1:0] num_reads_setting;
  pair_result_t expected_words [$];
  pair_row_t    pair_rows [$];

  int unsigned mismatch_count;
  int unsigned idle_pct;        // chance of an idle burst per word, both sides
  int unsigned hold_cycles;     // nonzero asks the receiver for one long hold-off
  logic [READ_ID_W-1:0] last_a, last_b;

  pair_match_min_max_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_num_reads     (cfg_num_reads),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_read_a         (in_read_a),
    .in_read_b         (in_read_b),
    .in_seed_score     (in_seed_score),
    .in_seed_freq      (in_seed_freq),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_count   (out_match_count),
    .out_lowest_score  (out_lowest_score),
    .out_lowest_freq   (out_lowest_freq),
    .out_highest_score (out_highest_score),
    .out_highest_freq  (out_highest_freq)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog. A correct run (reset sweep, ~1.15k words with gaps and stalls on
  // both sides, one hold-off) ends well inside this limit.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the block: folds one word into the table copy and returns the
  // result word the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic pair_result_t fold_pair_word(pmt_op_t op, logic [READ_ID_W-1:0] a,
                                                  logic [READ_ID_W-1:0] b,
                                                  logic signed [SCORE_W-1:0] score,
                                                  logic [FREQ_W-1:0] freq);
    int n;
    int idx;
    pmt_entry_t e;
    pair_result_t r;
    // registers above the table size fall back to the table size
    n = (int'(num_reads_setting) > TB_MAX_READS) ? TB_MAX_READS : int'(num_reads_setting);
    r = '0;
    // bad pair: flagged, zero fields, no table change (covers n < 2 too)
    if (int'(a) < 1 || int'(a) >= int'(b) || int'(b) > n) begin
      r.status = STAT_BAD;
      return r;
    end
    // triangular index of pair (a,b), a < b
    idx = ((2 * n - int'(a)) * (int'(a) - 1)) / 2 + int'(b) - int'(a) - 1;
    e = pair_entries[idx];
    if (op == OP_UPDATE) begin
      if (e.count == '0) begin
        // first shared seed: min and max both take it
        e.count    = COUNT_W'(1);
        e.lo_score = score;
        e.hi_score = score;
        e.lo_freq  = freq;
        e.hi_freq  = freq;
      end else begin
        // count saturates, min/max still tracked
        if (e.count != COUNT_MAX) e.count = e.count + 1'b1;
        if ($signed(score) < $signed(e.lo_score)) begin
          e.lo_score = score;
          e.lo_freq  = freq;
        end else if ($signed(score) > $signed(e.hi_score)) begin
          e.hi_score = score;
          e.hi_freq  = freq;
        end
      end
      pair_entries[idx] = e;
    end
    r.status   = STAT_OK;
    r.count    = e.count;
    r.lo_score = e.lo_score;
    r.lo_freq  = e.lo_freq;
    r.hi_score = e.hi_score;
    r.hi_freq  = e.hi_freq;
    return r;
  endfunction

  function automatic pair_result_t mk_result(pmt_status_t st, logic [COUNT_W-1:0] cnt,
                                             logic signed [SCORE_W-1:0] lo,
                                             logic [FREQ_W-1:0] lo_f,
                                             logic signed [SCORE_W-1:0] hi,
                                             logic [FREQ_W-1:0] hi_f);
    pair_result_t r;
    r.status   = st;
    r.count    = cnt;
    r.lo_score = lo;
    r.lo_freq  = lo_f;
    r.hi_score = hi;
    r.hi_freq  = hi_f;
    return r;
  endfunction

  task automatic add_row(pmt_op_t op, int a, int b, logic signed [SCORE_W-1:0] score,
                         logic [FREQ_W-1:0] freq);
    pair_row_t row;
    row.op        = op;
    row.a         = READ_ID_W'(a);
    row.b         = READ_ID_W'(b);
    row.score     = score;
    row.freq      = freq;
    row.has_fixed = 1'b0;
    row.fixed_res = '0;
    pair_rows.insert(pair_rows.size(), row);
  endtask

  // row whose result is written out by hand
  task automatic add_fixed_row(pmt_op_t op, int a, int b, logic signed [SCORE_W-1:0] score,
                               logic [FREQ_W-1:0] freq, pair_result_t res);
    add_row(op, a, b, score, freq);
    pair_rows[pair_rows.size() - 1].has_fixed = 1'b1;
    pair_rows[pair_rows.size() - 1].fixed_res = res;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers one word, holds it until taken, then queues its expected
  // result. An idle burst may come first when idling is on.
  // ---------------------------------------------------------------------------
  task automatic send_pair_word(pmt_op_t op, logic [READ_ID_W-1:0] a,
                                logic [READ_ID_W-1:0] b, logic signed [SCORE_W-1:0] score,
                                logic [FREQ_W-1:0] freq, bit has_fixed,
                                pair_result_t fixed_res);
    pair_result_t want;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_read_a     <= a;
    in_read_b     <= b;
    in_seed_score <= score;
    in_seed_freq  <= freq;
    // taken at the first edge with in_stall low
    do @(posedge clk); while (in_stall);
    want = fold_pair_word(op, a, b, score, freq);
    if (has_fixed) want = fixed_res;
    expected_words.insert(expected_words.size(), want);
  endtask

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(3))
      0: rand_score = {$urandom, $urandom};
      // narrow range so ties with min and max are common
      1: rand_score = $signed(SCORE_W'($urandom_range(16))) - 64'sd8;
      2: rand_score = $urandom_range(1) ? SCORE_MAX : SCORE_MIN;
      default: rand_score = $signed($urandom);
    endcase
  endfunction

  // Random word: mostly a valid pair under the current n (often the same pair
  // again, to hit the write-back forwarding), the rest noise over all ids.
  task automatic send_random_word();
    int n;
    pmt_op_t op;
    logic [READ_ID_W-1:0] a, b;
    logic [FREQ_W-1:0] freq;
    n = (int'(num_reads_setting) > TB_MAX_READS) ? TB_MAX_READS : int'(num_reads_setting);
    op = ($urandom_range(99) < 70) ? OP_UPDATE : OP_READ;
    if (n >= 2 && $urandom_range(99) < 88) begin
      if ($urandom_range(99) < 40 && last_a >= 1 && last_a < last_b && int'(last_b) <= n) begin
        a = last_a;
        b = last_b;
      end else begin
        a = READ_ID_W'($urandom_range(1, n - 1));
        b = READ_ID_W'($urandom_range(int'(a) + 1, n));
      end
    end else begin
      a = READ_ID_W'($urandom_range(127));
      b = READ_ID_W'($urandom_range(127));
    end
    freq = ($urandom_range(3) == 0) ? FREQ_W'($urandom_range(3)) : FREQ_W'($urandom);
    last_a = a;
    last_b = b;
    send_pair_word(op, a, b, rand_score(), freq, 1'b0, '0);
  endtask

  // num_reads may only change with the pipe empty: every word gives one
  // result, so an empty expectation queue plus a short pause is enough.
  task automatic set_num_reads(logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_num_reads <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    num_reads_setting = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random short stalls, plus one long hold-off on request so the
  // pipe fills and in_stall rises while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        out_stall   <= 1'b0;
        hold_cycles = 0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every taken result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    pair_result_t got;
    pair_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = mk_result(pmt_status_t'(out_status), out_match_count, out_lowest_score,
                      out_lowest_freq, out_highest_score, out_highest_freq);
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result word with none expected: st=%0d cnt=%0d", $realtime,
                   got.status, got.count);
      end else begin
        want = expected_words.pop_front();
        if (got.status != want.status || got.count != want.count ||
            got.lo_score != want.lo_score || got.lo_freq != want.lo_freq ||
            got.hi_score != want.hi_score || got.hi_freq != want.hi_freq) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch exp st=%0d cnt=%0d lo=%0d/%0h hi=%0d/%0h", $realtime,
                     want.status, want.count, want.lo_score, want.lo_freq,
                     want.hi_score, want.hi_freq);
            $display("%0t:          got st=%0d cnt=%0d lo=%0d/%0h hi=%0d/%0h", $realtime,
                     got.status, got.count, got.lo_score, got.lo_freq,
                     got.hi_score, got.hi_freq);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    pair_result_t zero_ok;
    pair_result_t bad_pair;
    // random phases: num_reads, word count, idle chance, long hold-off
    int unsigned phase_reads [7];
    int unsigned phase_words [7];
    int unsigned phase_idle  [7];
    int unsigned phase_hold  [7];

    phase_reads = '{2, 127, 1, 0, 9, 64, 33};
    phase_words = '{180, 230, 30, 30, 220, 230, 130};
    phase_idle  = '{30, 30, 25, 25, 0, 25, 20};
    phase_hold  = '{0, 40, 0, 0, 0, 0, 0};

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_num_reads     = NUM_READS_RST;
    in_valid          = 1'b0;
    in_operation      = OP_UPDATE;
    in_read_a         = '0;
    in_read_b         = '0;
    in_seed_score     = '0;
    in_seed_freq      = '0;
    num_reads_setting = NUM_READS_RST;
    mismatch_count    = 0;
    idle_pct          = 25;
    hold_cycles       = 0;
    last_a            = '0;
    last_b            = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) pair_entries[i] = '0;

    zero_ok  = mk_result(STAT_OK, '0, '0, '0, '0, '0);
    bad_pair = mk_result(STAT_BAD, '0, '0, '0, '0, '0);

    // Directed table, n = 64 from reset. Hand-typed results where obvious.
    // never-updated pairs read back as zeros
    add_fixed_row(OP_READ,   1,   2, '0, '0, zero_ok);
    add_fixed_row(OP_READ,  63,  64, '0, '0, zero_ok);
    // bad pairs: a = 0, a == b, a > b, b past n, ids all ones
    add_fixed_row(OP_UPDATE, 0,   5, SCORE_MAX, '1, bad_pair);
    add_fixed_row(OP_UPDATE, 5,   5, 64'sd3, 32'd3, bad_pair);
    add_fixed_row(OP_READ,   9,   3, '0, '0, bad_pair);
    add_fixed_row(OP_UPDATE, 1,  65, 64'sd1, 32'd1, bad_pair);
    add_fixed_row(OP_UPDATE, 127, 127, SCORE_MIN, '1, bad_pair);
    add_fixed_row(OP_READ,   64, 127, '0, '0, bad_pair);
    // first match sets min and max
    add_fixed_row(OP_UPDATE, 1,   2, SCORE_MAX, '1,
                  mk_result(STAT_OK, 16'd1, SCORE_MAX, '1, SCORE_MAX, '1));
    add_row(OP_UPDATE, 1, 2, SCORE_MIN, '0);          // new min
    add_row(OP_UPDATE, 1, 2, 64'sd0, 32'd1);          // between: no change
    add_row(OP_UPDATE, 1, 2, SCORE_MIN, 32'd7);       // tie with min: no change
    add_row(OP_READ,   1, 2, '0, '0);
    add_fixed_row(OP_UPDATE, 63, 64, -64'sd1, 32'hA5A5_A5A5,
                  mk_result(STAT_OK, 16'd1, -64'sd1, 32'hA5A5_A5A5, -64'sd1, 32'hA5A5_A5A5));
    add_row(OP_UPDATE, 63, 64, 64'sd5, 32'd3);        // new max
    add_row(OP_UPDATE, 63, 64, 64'sd5, 32'd9);        // tie with max
    add_row(OP_UPDATE, 63, 64, -64'sd2, 32'h5A5A_5A5A); // new min
    add_row(OP_UPDATE, 1, 64, SCORE_MAX, 32'hFFFF_0000);
    add_row(OP_UPDATE, 1, 64, SCORE_MIN, 32'h0000_FFFF);
    add_row(OP_READ,   1, 64, '0, '0);
    // back to back on one pair exercises the write-back forwarding path
    add_row(OP_UPDATE, 2, 3, 64'sd42, 32'd42);
    add_row(OP_UPDATE, 2, 3, 64'sd43, 32'd43);
    add_row(OP_UPDATE, 2, 3, 64'sd41, 32'd41);
    add_row(OP_READ,   2, 3, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset sweep keeps in_stall high; the first word simply waits it out
    foreach (pair_rows[i])
      send_pair_word(pair_rows[i].op, pair_rows[i].a, pair_rows[i].b, pair_rows[i].score,
                     pair_rows[i].freq, pair_rows[i].has_fixed, pair_rows[i].fixed_res);

    // random phases over several n, including both ends and out-of-range values
    for (int p = 0; p < 7; p++) begin
      set_num_reads(CFG_W'(phase_reads[p]));
      idle_pct    = phase_idle[p];
      hold_cycles = phase_hold[p];
      for (int i = 0; i < int'(phase_words[p]); i++) send_random_word();
    end

    // Last part, no idling: a full-rate run of updates on pair (1,2); random
    // scores keep min/max moving. Occasional reads and a bad pair are mixed in.
    set_num_reads(CFG_W'(2));
    idle_pct = 0;
    for (int i = 0; i < TAIL_UPDATES; i++) begin
      send_pair_word(OP_UPDATE, 7'd1, 7'd2, rand_score(), FREQ_W'($urandom), 1'b0, '0);
      if (i % 16 == 0) begin
        send_pair_word(OP_READ, 7'd1, 7'd2, '0, '0, 1'b0, '0);
        send_pair_word(OP_UPDATE, 7'd1, 7'd3, rand_score(), '1, 1'b0, '0);
      end
    end
    send_pair_word(OP_READ, 7'd1, 7'd2, '0, '0, 1'b0, '0);
    in_valid <= 1'b0;

    // drain, then a few cycles for anything stray
    while (expected_words.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pmt_pkg.sv
rtl/core/pmt_ram.sv
rtl/core/pmt_index.sv
rtl/core/pmt_update.sv
rtl/core/pair_match_min_max_table.sv
tb/sv/tb_pair_match_min_max_table.sv
